>>> hdl/lnh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram histogram: shared package
// Operation codes, fixed field widths and the per-item control bundle that
// travels from the window stage to the update stage.
// ----------------------------------------------------------------------------
package lnh_pkg;

   // Fixed field widths of the external channels
   localparam int LETTER_BITS = 5;
   localparam int CHAR_W      = 8;
   localparam int OUT_CODE_W  = 15;
   localparam int OUT_COUNT_W = 32;
   localparam int LEN_W       = 2;

   // gram_length after reset
   localparam logic [LEN_W-1:0] GRAM_LEN_RESET = 2'd2;

   typedef enum logic {
      OP_FEED  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Per-item control bundle
   typedef struct packed {
      logic valid;    // item present
      logic query;    // read one counter, no update
      logic counted;  // letter completed an n-gram: read-modify-write
   } lnh_ctrl_type;

endpackage

>>> hdl/lnh_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram histogram: channel interfaces
// Valid/ready channels for text/query items, results and the length register.
// ----------------------------------------------------------------------------

// Text byte or query item
interface lnh_req_if;
   logic                              valid;
   logic                              ready;
   lnh_pkg::op_type                   op;
   logic [lnh_pkg::CHAR_W-1:0]        char_byte;
   logic [lnh_pkg::OUT_CODE_W-1:0]    ngram_code;

   modport source (output valid, op, char_byte, ngram_code, input ready);
   modport sink   (input valid, op, char_byte, ngram_code, output ready);
endinterface

// Result item
interface lnh_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              gram_counted;
   logic [lnh_pkg::OUT_CODE_W-1:0]    gram_code;
   logic [lnh_pkg::OUT_COUNT_W-1:0]   gram_count;
   logic [lnh_pkg::OUT_COUNT_W-1:0]   total_out;

   modport source (output valid, gram_counted, gram_code, gram_count, total_out,
                   input ready);
   modport sink   (input valid, gram_counted, gram_code, gram_count, total_out,
                   output ready);
endinterface

// Length register write
interface lnh_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lnh_pkg::LEN_W-1:0]         gram_length;

   modport source (output valid, gram_length, input ready);
   modport sink   (input valid, gram_length, output ready);
endinterface

>>> hdl/letter_ngram_histogram_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram histogram: top level
// Path: an accepted item waits in the stage register with its read data,
// then moves to the result register when that is free or being emptied.
// Throughput: one item per cycle unless the result channel stalls; counter
// read-modify-write forwards the last write-back through a one-read
// one-write memory. Reset: the counter memory is zeroed after reset by a
// sweep over all 2^(5*MAX_GRAM) entries (32768 by default); no item is taken
// until it ends. gram_length resets to 2; its writes are taken at any time.
// ----------------------------------------------------------------------------
module letter_ngram_histogram_top #(
   parameter int MAX_GRAM    = 3,
   parameter int COUNT_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   lnh_req_if.sink       req_chan,
   lnh_rsp_if.source     rsp_chan,
   lnh_csr_if.sink       csr_chan
);

   localparam int ADDR_W = lnh_pkg::LETTER_BITS * MAX_GRAM;

   logic [lnh_pkg::LEN_W-1:0] gram_length_ff;
   logic                      accept;
   logic                      stage_ready;
   logic                      clear_busy;
   logic [ADDR_W-1:0]         s0_addr;
   lnh_pkg::lnh_ctrl_type     s0_ctrl;
   logic [COUNT_WIDTH-1:0]    rd_data;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [COUNT_WIDTH-1:0]    wr_data;

   // Length register
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gram_length_ff <= lnh_pkg::GRAM_LEN_RESET;
      end else if (csr_chan.valid) begin
         gram_length_ff <= csr_chan.gram_length;
      end
   end

   // Input handshake
   assign req_chan.ready = stage_ready && !clear_busy;
   assign accept         = req_chan.valid && req_chan.ready;

   lnh_window #(
      .MAX_GRAM (MAX_GRAM)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_chan.op),
      .char_byte   (req_chan.char_byte),
      .ngram_code  (req_chan.ngram_code),
      .gram_length (gram_length_ff),
      .addr        (s0_addr),
      .ctrl        (s0_ctrl)
   );

   lnh_count_ram #(
      .ADDR_W      (ADDR_W),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_count_ram (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (s0_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .clear_busy (clear_busy)
   );

   lnh_update #(
      .ADDR_W      (ADDR_W),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_update (
      .clock       (clock),
      .reset       (reset),
      .in_ctrl     (s0_ctrl),
      .in_addr     (s0_addr),
      .in_ready    (stage_ready),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_counted (rsp_chan.gram_counted),
      .out_code    (rsp_chan.gram_code),
      .out_count   (rsp_chan.gram_count),
      .out_total   (rsp_chan.total_out)
   );

endmodule

>>> hdl/lnh_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram histogram: letter window
// Folds text bytes to letter codes, keeps the recent-letter window and fill
// level, and forms the table address and control bits of each item.
// ----------------------------------------------------------------------------
module lnh_window #(
   parameter int MAX_GRAM = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  lnh_pkg::op_type                       op,
   input  logic [lnh_pkg::CHAR_W-1:0]            char_byte,
   input  logic [lnh_pkg::OUT_CODE_W-1:0]        ngram_code,
   input  logic [lnh_pkg::LEN_W-1:0]             gram_length,
   output logic [lnh_pkg::LETTER_BITS*MAX_GRAM-1:0] addr,
   output lnh_pkg::lnh_ctrl_type                 ctrl
);

   localparam int LB     = lnh_pkg::LETTER_BITS;
   localparam int ADDR_W = LB * MAX_GRAM;
   localparam int FILL_W = $clog2(MAX_GRAM + 1);
   localparam int CMP_W  = (FILL_W > lnh_pkg::LEN_W) ? FILL_W : lnh_pkg::LEN_W;

   localparam logic [lnh_pkg::CHAR_W-1:0] UPPER_A = 8'h41;
   localparam logic [lnh_pkg::CHAR_W-1:0] UPPER_Z = 8'h5A;
   localparam logic [lnh_pkg::CHAR_W-1:0] LOWER_A = 8'h61;
   localparam logic [lnh_pkg::CHAR_W-1:0] LOWER_Z = 8'h7A;

   logic [ADDR_W-1:0] window_ff;
   logic [ADDR_W-1:0] window_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              is_letter;
   logic [LB-1:0]     code;
   logic [CMP_W-1:0]  len_eff;
   logic [CMP_W-1:0]  len_raw;
   logic [ADDR_W-1:0] gmask;
   logic              feed;

   // Case fold: letter flag and code 0..25
   always_comb begin
      is_letter = 1'b0;
      code      = '0;
      if (char_byte inside {[UPPER_A:UPPER_Z]}) begin
         is_letter = 1'b1;
         code      = LB'(char_byte - UPPER_A);
      end else if (char_byte inside {[LOWER_A:LOWER_Z]}) begin
         is_letter = 1'b1;
         code      = LB'(char_byte - LOWER_A);
      end
   end

   // Effective n-gram length, clamped to 1..MAX_GRAM
   always_comb begin
      len_raw = CMP_W'(gram_length);
      if (len_raw == '0) begin
         len_eff = CMP_W'(1);
      end else if (len_raw > CMP_W'(MAX_GRAM)) begin
         len_eff = CMP_W'(MAX_GRAM);
      end else begin
         len_eff = len_raw;
      end
   end

   // Mask keeps the newest len_eff letters
   always_comb begin
      gmask = '0;
      for (int k = 0; k < MAX_GRAM; k++) begin
         if (CMP_W'(k) < len_eff) begin
            gmask[k*LB +: LB] = '1;
         end
      end
   end

   // Next window and fill level for a letter
   assign window_in = ADDR_W'({window_ff, code});
   assign fill_in   = (fill_ff < FILL_W'(MAX_GRAM)) ? fill_ff + FILL_W'(1) : fill_ff;
   assign feed      = (op == lnh_pkg::OP_FEED);

   // Address and control of the item on the channel
   always_comb begin
      ctrl.valid   = accept;
      ctrl.query   = (op == lnh_pkg::OP_QUERY);
      ctrl.counted = feed && is_letter && (CMP_W'(fill_in) >= len_eff);
      if (op == lnh_pkg::OP_QUERY) begin
         addr = ADDR_W'(ngram_code);
      end else begin
         addr = window_in & gmask;
      end
   end

   // Window state moves only on accepted letters
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= '0;
      end else if (accept && feed && is_letter) begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> hdl/lnh_count_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram histogram: counter memory
// One-read one-write synchronous memory with registered read data, plus the
// clearing sweep that zeroes every entry after reset.
// ----------------------------------------------------------------------------
module lnh_count_ram #(
   parameter int ADDR_W      = 15,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output logic [COUNT_WIDTH-1:0] rd_data,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [COUNT_WIDTH-1:0] wr_data,
   output logic                   clear_busy
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [COUNT_WIDTH-1:0] mem [DEPTH];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   clear_busy_ff;
   logic [ADDR_W-1:0]      clear_addr_ff;

   // Clearing sweep, one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_busy_ff) begin
         clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
         if (clear_addr_ff == '1) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   // Write port: sweep or counter update
   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         mem[clear_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clear_busy_ff;

   // No counter update may collide with the sweep
   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      !(clear_busy_ff && wr_en))
      else $error("counter write during clearing sweep");

   // Sweep ends only after the last entry
   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_busy_ff) |-> $past(clear_addr_ff) == '1)
      else $error("clearing sweep ended early");

endmodule

>>> hdl/lnh_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram histogram: update stage
// Takes read data (with forwarding of the last write), for counted n-grams
// increments counter and total with saturation and writes back, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module lnh_update #(
   parameter int ADDR_W      = 15,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lnh_pkg::lnh_ctrl_type              in_ctrl,
   input  logic [ADDR_W-1:0]                  in_addr,
   output logic                               in_ready,
   input  logic [COUNT_WIDTH-1:0]             rd_data,
   output logic                               wr_en,
   output logic [ADDR_W-1:0]                  wr_addr,
   output logic [COUNT_WIDTH-1:0]             wr_data,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic                               out_counted,
   output logic [lnh_pkg::OUT_CODE_W-1:0]     out_code,
   output logic [lnh_pkg::OUT_COUNT_W-1:0]    out_count,
   output logic [lnh_pkg::OUT_COUNT_W-1:0]    out_total
);

   localparam int CW = lnh_pkg::OUT_COUNT_W;

   lnh_pkg::lnh_ctrl_type  s1_ctrl_ff;
   logic [ADDR_W-1:0]      s1_addr_ff;
   logic                   last_wr_valid_ff;
   logic [ADDR_W-1:0]      last_wr_addr_ff;
   logic [COUNT_WIDTH-1:0] last_wr_data_ff;
   logic [COUNT_WIDTH-1:0] total_ff;
   logic [COUNT_WIDTH-1:0] total_in;
   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   s1_adv;
   logic                   fwd_hit;

   logic                        out_valid_ff;
   logic                        out_counted_ff;
   logic [lnh_pkg::OUT_CODE_W-1:0] out_code_ff;
   logic [CW-1:0]               out_count_ff;
   logic [CW-1:0]               out_total_ff;

   // Stage advance and upstream ready
   assign s1_adv   = s1_ctrl_ff.valid && (!out_valid_ff || out_ready);
   assign in_ready = !s1_ctrl_ff.valid || s1_adv;

   // Forward the most recent write over stale read data
   assign fwd_hit   = last_wr_valid_ff && (last_wr_addr_ff == s1_addr_ff);
   assign cur_count = fwd_hit ? last_wr_data_ff : rd_data;

   // Saturating increments
   assign count_in = (cur_count == '1) ? cur_count : cur_count + COUNT_WIDTH'(1);
   assign total_in = (total_ff == '1) ? total_ff : total_ff + COUNT_WIDTH'(1);

   // Write-back
   assign wr_en   = s1_adv && s1_ctrl_ff.counted;
   assign wr_addr = s1_addr_ff;
   assign wr_data = count_in;

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
      end else if (in_ready) begin
         s1_ctrl_ff <= in_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         s1_addr_ff <= in_addr;
      end
   end

   // Last write and total
   always_ff @(posedge clock) begin
      if (reset) begin
         last_wr_valid_ff <= 1'b0;
         total_ff         <= '0;
      end else if (wr_en) begin
         last_wr_valid_ff <= 1'b1;
         total_ff         <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         last_wr_addr_ff <= wr_addr;
         last_wr_data_ff <= wr_data;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         if (s1_ctrl_ff.counted) begin
            out_counted_ff <= 1'b1;
            out_code_ff    <= lnh_pkg::OUT_CODE_W'(s1_addr_ff);
            out_count_ff   <= CW'(count_in);
            out_total_ff   <= CW'(total_in);
         end else if (s1_ctrl_ff.query) begin
            out_counted_ff <= 1'b0;
            out_code_ff    <= lnh_pkg::OUT_CODE_W'(s1_addr_ff);
            out_count_ff   <= CW'(cur_count);
            out_total_ff   <= CW'(total_ff);
         end else begin
            out_counted_ff <= 1'b0;
            out_code_ff    <= '0;
            out_count_ff   <= '0;
            out_total_ff   <= CW'(total_ff);
         end
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_counted = out_counted_ff;
   assign out_code    = out_code_ff;
   assign out_count   = out_count_ff;
   assign out_total   = out_total_ff;

   // Every counted n-gram leaves a nonzero total
   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> total_ff != '0)
      else $error("total zero after a counted n-gram");

   // Forwarding register tracks each write-back
   a_fwd_tracks_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> last_wr_valid_ff && (last_wr_addr_ff == $past(wr_addr)))
      else $error("forwarding register missed a write-back");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letter n-gram histogram: block-level testbench
// Feeds text bytes and count queries through the request channel. An
// item-level predictor keeps its own letter window, counter table and total.
// Every result is checked field by field against the oldest prediction. The
// run covers all gram lengths, including the out-of-range zero, and several
// patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;

   localparam int TABLE_DEPTH = 1 << (lnh_pkg::LETTER_BITS * 3);
   localparam int STALL_LIMIT = 140000;   // covers the clearing sweep several times
   localparam int LONG_HOLD   = 300;

   // ASCII letter bounds
   localparam logic [7:0] CH_UP_A = 8'h41;
   localparam logic [7:0] CH_UP_Z = 8'h5A;
   localparam logic [7:0] CH_LO_A = 8'h61;
   localparam logic [7:0] CH_LO_Z = 8'h7A;

   typedef struct {
      lnh_pkg::op_type                      op;
      logic [lnh_pkg::CHAR_W-1:0]           ch;
      logic [lnh_pkg::OUT_CODE_W-1:0]       code;
   } hist_req_type;

   typedef struct {
      logic                                 counted;
      logic [lnh_pkg::OUT_CODE_W-1:0]       code;
      logic [lnh_pkg::OUT_COUNT_W-1:0]      count;
      logic [lnh_pkg::OUT_COUNT_W-1:0]      total;
   } hist_rsp_type;

   logic clock;
   logic reset;

   lnh_req_if req_chan ();
   lnh_rsp_if rsp_chan ();
   lnh_csr_if csr_chan ();

   letter_ngram_histogram_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predictor state
   logic [lnh_pkg::LEN_W-1:0]       cfg_len = lnh_pkg::GRAM_LEN_RESET;
   logic [lnh_pkg::OUT_CODE_W-1:0]  win_codes = '0;
   int                              letters_held = 0;
   bit   [lnh_pkg::OUT_COUNT_W-1:0] gram_tally [TABLE_DEPTH];
   bit   [lnh_pkg::OUT_COUNT_W-1:0] gram_sum = '0;

   // Stimulus and scoreboard
   hist_req_type  req_backlog [$];
   hist_rsp_type  tallies_due [$];
   hist_req_type  on_wire;
   hist_rsp_type  due;
   int            stim_len = 2;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   logic          rsp_hold = 1'b0;
   int            quiet_cycles = 0;

   int mismatches = 0;
   int items_fed = 0;
   int queries_fed = 0;
   int results_checked = 0;
   int grams_seen = 0;
   int lengths_written = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int eff_len(logic [lnh_pkg::LEN_W-1:0] len);
      return (len == 0) ? 1 : int'(len);
   endfunction

   function automatic logic [lnh_pkg::OUT_COUNT_W-1:0] sat_inc(
      logic [lnh_pkg::OUT_COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Predict one item's result and advance the histogram state
   function automatic hist_rsp_type tally_item(hist_req_type it);
      hist_rsp_type                   r;
      logic [4:0]                     ltr;
      logic                           is_ltr;
      logic [15:0]                    gmask;
      logic [lnh_pkg::OUT_CODE_W-1:0] addr;
      int                             n;
      r.counted = 1'b0;
      r.code    = '0;
      r.count   = '0;
      n         = eff_len(cfg_len);
      if (it.op == lnh_pkg::OP_QUERY) begin
         r.code  = it.code;
         r.count = gram_tally[it.code];
         r.total = gram_sum;
         return r;
      end
      is_ltr = 1'b1;
      ltr    = '0;
      if (it.ch >= CH_UP_A && it.ch <= CH_UP_Z) ltr = 5'(it.ch - CH_UP_A);
      else if (it.ch >= CH_LO_A && it.ch <= CH_LO_Z) ltr = 5'(it.ch - CH_LO_A);
      else is_ltr = 1'b0;
      if (is_ltr) begin
         win_codes = {win_codes[lnh_pkg::OUT_CODE_W-lnh_pkg::LETTER_BITS-1:0], ltr};
         if (letters_held < 3) letters_held++;
         if (letters_held >= n) begin
            gmask = (16'd1 << (lnh_pkg::LETTER_BITS * n)) - 16'd1;
            addr  = win_codes & gmask[lnh_pkg::OUT_CODE_W-1:0];
            gram_tally[addr] = sat_inc(gram_tally[addr]);
            gram_sum  = sat_inc(gram_sum);
            r.counted = 1'b1;
            r.code    = addr;
            r.count   = gram_tally[addr];
         end
      end
      r.total = gram_sum;
      return r;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // Letters that recur often, so counts build up
   function automatic logic [4:0] common_letter();
      case ($urandom_range(3))
         0:       return 5'd0;
         1:       return 5'd4;
         2:       return 5'd19;
         default: return 5'd25;
      endcase
   endfunction

   function automatic logic [7:0] letter_byte(logic [4:0] code, bit upper);
      return upper ? CH_UP_A + 8'(code) : CH_LO_A + 8'(code);
   endfunction

   function automatic void push_feed(logic [7:0] ch);
      hist_req_type it;
      it.op   = lnh_pkg::OP_FEED;
      it.ch   = ch;
      it.code = 15'($urandom_range(32767));
      req_backlog.insert(req_backlog.size(), it);
   endfunction

   function automatic void push_query(logic [lnh_pkg::OUT_CODE_W-1:0] code);
      hist_req_type it;
      it.op   = lnh_pkg::OP_QUERY;
      it.ch   = 8'($urandom_range(255));
      it.code = code;
      req_backlog.insert(req_backlog.size(), it);
   endfunction

   // Mostly letters from a small alphabet, some noise bytes, some queries
   function automatic void queue_random(int count);
      int                             pick;
      logic [4:0]                     ltr;
      logic [lnh_pkg::OUT_CODE_W-1:0] code;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            ltr = ($urandom_range(3) == 0) ? 5'($urandom_range(25)) : common_letter();
            push_feed(letter_byte(ltr, 1'($urandom_range(1))));
         end else if (pick < 70) begin
            push_feed(8'($urandom_range(255)));
         end else if ($urandom_range(3) == 0) begin
            push_query(15'($urandom_range(32767)));
         end else begin
            code = '0;
            for (int k = 0; k < stim_len; k++)
               code = {code[lnh_pkg::OUT_CODE_W-lnh_pkg::LETTER_BITS-1:0], common_letter()};
            push_query(code);
         end
      end
   endfunction

   // Length register write; returns at a falling edge
   task automatic write_gram_length(logic [lnh_pkg::LEN_W-1:0] len);
      @(posedge clock);
      csr_chan.valid       <= 1'b1;
      csr_chan.gram_length <= len;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      cfg_len  = len;
      stim_len = eff_len(len);
      lengths_written++;
      @(negedge clock);
   endtask

   // Wait until every item is sent and every result has come back
   task automatic drain();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_chan.valid || tallies_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Request driver: predicts each accepted item, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            tallies_due.insert(tallies_due.size(), tally_item(on_wire));
            items_fed++;
            if (on_wire.op == lnh_pkg::OP_QUERY) queries_fed++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_wire = req_backlog.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.op         <= on_wire.op;
               req_chan.char_byte  <= on_wire.ch;
               req_chan.ngram_code <= on_wire.code;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_checked++;
            if (rsp_chan.gram_counted === 1'b1) grams_seen++;
            if (tallies_due.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual code %h count %h",
                        $time, rsp_chan.gram_code, rsp_chan.gram_count);
               mismatches++;
            end else begin
               due = tallies_due.pop_front();
               check_field("gram_counted", 32'(due.counted), 32'(rsp_chan.gram_counted));
               check_field("gram_code", 32'(due.code), 32'(rsp_chan.gram_code));
               check_field("gram_count", due.count, rsp_chan.gram_count);
               check_field("total_out", due.total, rsp_chan.total_out);
            end
         end
         rsp_chan.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, quiet_cycles);
         $display("letter_ngram_histogram_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence
   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.op          = lnh_pkg::OP_FEED;
      req_chan.char_byte   = '0;
      req_chan.ngram_code  = '0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.gram_length = lnh_pkg::GRAM_LEN_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Single letters: the very first letter counts
      write_gram_length(2'd1);
      push_feed(8'h00);
      push_feed(letter_byte(5'd16, 1'b1));
      push_feed(8'hFF);
      push_query(15'd16);
      drain();

      // Pairs: window kept across the change, letter bounds, bad-group query
      write_gram_length(2'd2);
      push_feed(CH_UP_A);
      push_feed(CH_UP_A - 8'd1);
      push_feed(CH_LO_Z);
      push_feed(CH_UP_Z + 8'd1);
      push_feed(CH_LO_A - 8'd1);
      push_feed(CH_LO_Z + 8'd1);
      push_feed(CH_UP_Z);
      push_feed(CH_LO_A);
      push_query(15'd25);
      push_query(15'h7FFF);
      push_query(15'd0);
      drain();

      // Triples formed at once from the held window
      write_gram_length(2'd3);
      push_feed(letter_byte(5'd4, 1'b0));
      push_query({5'd25, 5'd0, 5'd4});
      drain();

      // Zero length acts as one
      write_gram_length(2'd0);
      push_feed(letter_byte(5'd4, 1'b0));
      push_feed(letter_byte(5'd4, 1'b1));
      push_query(15'd4);
      drain();

      // Random phases over lengths and flow-control patterns
      write_gram_length(2'd3);
      queue_random(65);
      drain();

      write_gram_length(2'd2);
      send_idle_pct = 48;
      queue_random(65);
      drain();

      write_gram_length(2'd1);
      send_idle_pct  = 0;
      recv_stall_pct = 48;
      queue_random(65);
      drain();

      write_gram_length(2'd3);
      send_idle_pct  = 29;
      recv_stall_pct = 29;
      queue_random(65);
      drain();

      // Long receiver hold while the sender keeps offering
      write_gram_length(2'd2);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            rsp_hold = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      queue_random(70);
      drain();

      write_gram_length(2'd0);
      send_idle_pct  = 29;
      recv_stall_pct = 29;
      queue_random(65);
      drain();

      repeat (8) @(posedge clock);
      $display("Run: %0d items (%0d queries), %0d results checked, %0d n-grams counted",
               items_fed, queries_fed, results_checked, grams_seen);
      $display("     %0d length writes over lengths 0..3, %0d mismatches",
               lengths_written, mismatches);
      if (mismatches == 0) begin
         $display("letter_ngram_histogram_top verification clean");
      end else begin
         $display("letter_ngram_histogram_top verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/lnh_pkg.sv
hdl/lnh_channels.sv
hdl/lnh_window.sv
hdl/lnh_count_ram.sv
hdl/lnh_update.sv
hdl/letter_ngram_histogram_top.sv
test/tb.sv
